### design/ccks_pkg.sv
// ----------------------------------------------------------------------------
// ccks_pkg: shared types and helpers for the ChaCha keystream generator
// Item layouts, register indexes and the two halves of the quarter-round.
// ----------------------------------------------------------------------------
package ccks_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned NUM_WORDS = 16;
  localparam logic [4:0]  ROUND_RESET = 5'd20;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    REG_CONST_LO = 3'd0,
    REG_CONST_HI = 3'd1,
    REG_KEY_A    = 3'd2,
    REG_KEY_B    = 3'd3,
    REG_KEY_C    = 3'd4,
    REG_KEY_D    = 3'd5,
    REG_NONCE    = 3'd6,
    REG_ROUNDS   = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_GENERATE = 1'b0,
    OP_LOAD     = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic [63:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] keystream_word;
    logic [3:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // First two steps of the quarter-round.
  function automatic quad_t qr_first(quad_t q);
    quad_t r;
    r   = q;
    r.a = r.a + r.b;
    r.d = rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d;
    r.b = rotl(r.b ^ r.c, 12);
    return r;
  endfunction

  // Last two steps of the quarter-round.
  function automatic quad_t qr_second(quad_t q);
    quad_t r;
    r   = q;
    r.a = r.a + r.b;
    r.d = rotl(r.d ^ r.a, 8);
    r.c = r.c + r.d;
    r.b = rotl(r.b ^ r.c, 7);
    return r;
  endfunction

endpackage

### design/chacha_keystream_generator.sv
// ----------------------------------------------------------------------------
// chacha_keystream_generator: ChaCha block function keystream source
// Generates sixteen 32-bit keystream words per generate item.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write constants, key, nonce and round count through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
//   Input channel (in_valid_i / in_ready_o): an item with opcode load sets
//   the 64-bit block counter and yields nothing. An item with
//   opcode generate yields sixteen output items, words 0..15, the last
//   flagged by last_word; the counter then advances (wrapping at 2^64).
//   A generate item first fills the state memory, then runs the rounds
//   (ceil(rounds/2) double rounds), then reads out the output words; the
//   next item is accepted in the cycle after the last word is loaded.
//   One item is worked on at a time.
//   The working state sits in a 4-lane x 4-entry memory with a registered
//   read; a quarter-round is issued per cycle and a round drains its
//   two-stage pipeline before the next round reads, which sets the rate.
//   Stalls at out_ready_i hold the output register and pause the readout.
//   Reset clears the counter and registers (round count becomes twenty).
// ----------------------------------------------------------------------------
module chacha_keystream_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccks_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccks_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ORD   = 5'b01000,
    ST_OWAIT = 5'b10000
  } state_e;

  localparam logic [2:0] PH_LAST = 3'd5;

  state_e      state_q, state_d;
  logic [63:0] cfg_q [7];
  logic [4:0]  rounds_q;
  logic [63:0] ctr_q, ctr_d;
  logic [2:0]  ph_q, ph_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  idx_q, idx_d;
  logic [5:0]  nhr;

  // Working-state memory: lane l holds word 4*l+s at entry s.
  ccks_pkg::word_t mem_q [4][4];
  ccks_pkg::word_t rd_q [4];
  logic [1:0]      raddr [4];
  logic [1:0]      waddr [4];
  ccks_pkg::word_t wdata [4];
  logic            re, we;

  // Quarter-round pipeline.
  logic           p1_q, p2_q;
  logic [1:0]     p1_addr_q [4];
  logic [1:0]     p2_addr_q [4];
  ccks_pkg::quad_t s1_q, s2;

  ccks_pkg::word_t init_w [16];
  ccks_pkg::out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Two half-rounds per double round; odd counts round up.
  assign nhr = (6'({1'b0, rounds_q}) + 6'd1) & 6'h3E;

  // Input block, built from the registers and the counter.
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      init_w[2*p]   = cfg_q[p][31:0];
      init_w[2*p+1] = cfg_q[p][63:32];
    end
    init_w[12] = ctr_q[31:0];
    init_w[13] = ctr_q[63:32];
    init_w[14] = cfg_q[6][31:0];
    init_w[15] = cfg_q[6][63:32];
  end

  // Read addresses: column round uses one entry across lanes, diagonal
  // round skews each lane by its number.
  always_comb begin
    re = 1'b0;
    for (int l = 0; l < 4; l++) begin
      raddr[l] = idx_q[1:0];
      if (state_q == ST_ROUND) begin
        raddr[l] = ph_q[1:0] + (rnd_q[0] ? 2'(l) : 2'd0);
      end
    end
    if (state_q == ST_ROUND && !ph_q[2]) begin
      re = 1'b1;
    end else if (state_q == ST_ORD) begin
      re = 1'b1;
    end
  end

  assign s2 = ccks_pkg::qr_second(s1_q);

  // Write side: fill from the input block, else retire the pipeline.
  always_comb begin
    we = 1'b0;
    for (int l = 0; l < 4; l++) begin
      waddr[l] = p2_addr_q[l];
      wdata[l] = '0;
    end
    wdata[0] = s2.a;
    wdata[1] = s2.b;
    wdata[2] = s2.c;
    wdata[3] = s2.d;
    if (state_q == ST_INIT) begin
      we = 1'b1;
      for (int l = 0; l < 4; l++) begin
        waddr[l] = ph_q[1:0];
        wdata[l] = init_w[{2'(l), ph_q[1:0]}];
      end
    end else if (p2_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      if (we) begin
        mem_q[l][waddr[l]] <= wdata[l];
      end
      if (re) begin
        rd_q[l] <= mem_q[l][raddr[l]];
      end
    end
    s1_q <= ccks_pkg::qr_first(
      ccks_pkg::quad_t'{a: rd_q[0], b: rd_q[1], c: rd_q[2], d: rd_q[3]});
    for (int l = 0; l < 4; l++) begin
      if (re) begin
        p1_addr_q[l] <= raddr[l];
      end
      p2_addr_q[l] <= p1_addr_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= 1'b0;
      p2_q <= 1'b0;
    end else begin
      p1_q <= re && (state_q == ST_ROUND);
      p2_q <= p1_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    ph_d        = ph_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        ph_d  = '0;
        rnd_d = '0;
        idx_d = '0;
        if (in_valid_i) begin
          if (in_data_i.opcode == ccks_pkg::OP_LOAD) begin
            ctr_d = in_data_i.counter_value;
          end else begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ph_d = ph_q + 3'd1;
        if (ph_q[1:0] == 2'd3) begin
          ph_d    = '0;
          state_d = (nhr == 6'd0) ? ST_ORD : ST_ROUND;
        end
      end
      ST_ROUND: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == PH_LAST) begin
          ph_d  = '0;
          rnd_d = rnd_q + 6'd1;
          if (rnd_q + 6'd1 == nhr) begin
            state_d = ST_ORD;
          end
        end
      end
      ST_ORD: begin
        state_d = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.keystream_word = rd_q[idx_q[3:2]] + init_w[idx_q];
          out_d.word_index     = idx_q;
          out_d.last_word      = (idx_q == 4'd15);
          idx_d                = idx_q + 4'd1;
          state_d              = ST_ORD;
          if (idx_q == 4'd15) begin
            ctr_d   = ctr_q + 64'd1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      ph_q        <= '0;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      rounds_q    <= ccks_pkg::ROUND_RESET;
      for (int p = 0; p < 7; p++) begin
        cfg_q[p] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      ph_q        <= ph_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ccks_pkg::REG_ROUNDS) begin
          rounds_q <= cfg_wdata_i[4:0];
        end else begin
          cfg_q[cfg_idx_i] <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  // Write-back only happens while rounds run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_q |-> state_q == ST_ROUND)
    else $error("quarter-round retired outside a round");

  // Interlock: a round starts reading only after the previous one drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && ph_q == 3'd0) |-> (!p1_q && !p2_q))
    else $error("round read overlaps pending write-back");

  // A generate item goes straight to filling the state memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.opcode == ccks_pkg::OP_GENERATE)
    |=> state_q == ST_INIT)
    else $error("generate item not started");
`endif

endmodule
